// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL in this folder.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sitda_pkg.sv -----
// Package for the signed integer to decimal text core.
// Holds the character type and the ASCII codes; no dependencies.
package sitda_pkg;

  typedef logic [6:0] char_t;

  localparam char_t CH_ZERO  = 7'h30;
  localparam char_t CH_MINUS = 7'h2D;
  localparam char_t CH_BLANK = 7'h20;

  // BCD digits at or above this value get the double-dabble correction
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

endpackage

// ----- rtl/core/signed_int_to_decimal_ascii_core.sv -----
// Signed integer to decimal ASCII text, one character per output transfer.
// Input channel in_valid/in_ready carries in_value, a signed two's complement
// word of VALUE_BITS bits. Output channel out_valid/out_ready carries
// out_character (blank, '-', or a digit) and out_last on the final character.
// cfg_wr_en/cfg_wr_data set the minimum field width; blanks pad on the left,
// values above MAX_FIELD act as MAX_FIELD, zero means no padding.
// One value at a time: in_ready is high only while the core is idle.
// Conversion shifts the magnitude into a BCD register one bit per cycle,
// then drops leading zero digits one per cycle and sizes the padding, emits
// the blanks, turns to the sign or the digits, then emits the sign and the
// digits, and returns to idle with in_ready high.
// When the receiver stalls the output register holds its character and the
// emitter waits. Synchronous reset clears the sequencer, the output valid
// and the field width (to 0).
// Depends on sitda_pkg and assert_macros.svh.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_core
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_FIELD  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [6:0]            out_character,
  output logic                  out_last,
  input  logic                  cfg_wr_en,
  input  logic [4:0]            cfg_wr_data
);

  // Enough decimal digits for a magnitude of 2^(VALUE_BITS-1)
  localparam int ND   = (VALUE_BITS * 3) / 10 + 1;
  localparam int NDW  = $clog2(ND + 1);
  localparam int BCW  = $clog2(VALUE_BITS);
  localparam int CW   = $clog2(MAX_FIELD + ND + 34);
  localparam int BCDW = ND * 4;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CONV   = 3'd1;
  localparam logic [2:0] S_STRIP  = 3'd2;
  localparam logic [2:0] S_PAD    = 3'd3;
  localparam logic [2:0] S_SIGN   = 3'd4;
  localparam logic [2:0] S_DIGITS = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCDW-1:0]       bcd_r, bcd_nxt;
  logic [BCW-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic [NDW-1:0]        ndig_r, ndig_nxt;
  logic [CW-1:0]         pad_r, pad_nxt;
  logic                  neg_r, neg_nxt;
  logic [4:0]            field_width_r;
  logic                  out_valid_r, out_valid_nxt;
  char_t                 out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  can_load;
  logic [BCDW-1:0]       bcd_adj;
  logic [3:0]            top_digit;
  logic [VALUE_BITS-1:0] in_mag;
  logic [CW-1:0]         eff_width, text_len, fw_ext, max_ext;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign can_load      = !out_valid_r || out_ready;
  assign top_digit     = bcd_r[BCDW-1 -: 4];

  // Magnitude of the input; the most negative value wraps to 2^(N-1) exactly
  assign in_mag = in_value[VALUE_BITS-1]
                ? (~in_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_value;

  // Double-dabble correction on each digit before the shift
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= BCD_ADJ_MIN)
                        ? bcd_r[i*4 +: 4] + BCD_ADJ_ADD : bcd_r[i*4 +: 4];
    end
  end

  // Padding length from the clamped width and the text length
  assign fw_ext    = CW'(field_width_r);
  assign max_ext   = CW'(MAX_FIELD);
  assign eff_width = (fw_ext > max_ext) ? max_ext : fw_ext;
  assign text_len  = CW'(ndig_r) + CW'(neg_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    ndig_nxt      = ndig_r;
    pad_nxt       = pad_r;
    neg_nxt       = neg_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mag_nxt     = in_mag;
          neg_nxt     = in_value[VALUE_BITS-1];
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          ndig_nxt    = NDW'(ND);
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt     = {bcd_adj[BCDW-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BCW'(1);
        if (bit_cnt_r == BCW'(VALUE_BITS - 1)) begin
          state_nxt = S_STRIP;
        end
      end
      S_STRIP: begin
        // Drop one leading zero digit per cycle, keep at least one digit
        if (top_digit == 4'd0 && ndig_r > NDW'(1)) begin
          bcd_nxt  = {bcd_r[BCDW-5:0], 4'd0};
          ndig_nxt = ndig_r - NDW'(1);
        end else begin
          pad_nxt   = (eff_width > text_len) ? eff_width - text_len : '0;
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        if (pad_r == '0) begin
          state_nxt = neg_r ? S_SIGN : S_DIGITS;
        end else if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_BLANK;
          out_last_nxt  = 1'b0;
          pad_nxt       = pad_r - CW'(1);
        end
      end
      S_SIGN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO | {3'b000, top_digit};
          out_last_nxt  = (ndig_r == NDW'(1));
          bcd_nxt       = {bcd_r[BCDW-5:0], 4'd0};
          ndig_nxt      = ndig_r - NDW'(1);
          if (ndig_r == NDW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      field_width_r <= 5'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        field_width_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    ndig_r     <= ndig_nxt;
    pad_r      <= pad_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Checks
  `ASSERT_NXT(a_no_out_while_conv,
              (state_r == S_CONV || state_r == S_STRIP) && !out_valid_r,
              !out_valid_r, "character emitted during conversion")
  `ASSERT_IMP(a_digits_left, state_r == S_DIGITS, ndig_r != '0,
              "digit state with no digits left")
  `ASSERT_NXT(a_last_ends_item,
              state_r == S_DIGITS && can_load && ndig_r == NDW'(1),
              state_r == S_IDLE && out_valid_r && out_last_r,
              "final digit did not end the item")

endmodule

// ----- test/tb_signed_int_to_decimal_ascii_core.sv -----
// Testbench for signed_int_to_decimal_ascii_core: drives signed words, sets the
// field width and checks every emitted character against a predicted text.
// Depends on sitda_pkg and the core; stands alone otherwise.
module tb_signed_int_to_decimal_ascii_core;
  import sitda_pkg::*;

  localparam int VALUE_BITS   = 32;
  localparam int MAX_FIELD    = 16;
  localparam int RESET_CYCLES = 7;
  localparam int SEG_ITEMS    = 20;
  // Conversion runs with no transfer, and stalls lengthen such quiet spans
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = VALUE_BITS + MAX_FIELD + 16;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    char_t character;
    logic  last;
  } text_char_t;

  // Predicted character stream and its checker
  class decimal_text_scoreboard;
    text_char_t  expected_text[$];
    logic [4:0]  width_setting;
    int          errors;

    function new();
      width_setting = '0;
      errors = 0;
    endfunction

    function void set_width(logic [4:0] w);
      width_setting = w;
    endfunction

    function int pending();
      return expected_text.size();
    endfunction

    task flag_mismatch(string what);
      if (errors < PRINT_LIMIT)
        $display("mismatch @%0t: %s", $realtime, what);
      errors++;
    endtask

    // Blanks up to the clamped width, then the sign, then the digits
    function void note_value(logic [VALUE_BITS-1:0] word);
      logic [VALUE_BITS-1:0] magnitude;
      char_t      digits[$];
      int         text_len;
      int         field;
      int         i;
      text_char_t entry;
      magnitude = word[VALUE_BITS-1] ? (~word + 1'b1) : word;
      do begin
        digits.push_front(char_t'(CH_ZERO + magnitude % 10));
        magnitude = magnitude / 10;
      end while (magnitude != 0);
      text_len = digits.size() + (word[VALUE_BITS-1] ? 1 : 0);
      field = (width_setting > MAX_FIELD) ? MAX_FIELD : int'(width_setting);
      entry.last = 1'b0;
      for (i = text_len; i < field; i++) begin
        entry.character = CH_BLANK;
        expected_text.push_back(entry);
      end
      if (word[VALUE_BITS-1]) begin
        entry.character = CH_MINUS;
        expected_text.push_back(entry);
      end
      for (i = 0; i < digits.size(); i++) begin
        entry.character = digits[i];
        entry.last = (i == digits.size() - 1);
        expected_text.push_back(entry);
      end
    endfunction

    task check_char(char_t got_char, logic got_last);
      text_char_t want;
      if (expected_text.size() == 0) begin
        flag_mismatch($sformatf("unexpected character 0x%02h last %0b", got_char, got_last));
      end else begin
        want = expected_text.pop_front();
        if (got_char !== want.character)
          flag_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                  got_char, want.character));
        if (got_last !== want.last)
          flag_mismatch($sformatf("last %0b, expected %0b on character 0x%02h",
                                  got_last, want.last, want.character));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [6:0]            out_character;
  logic                  out_last;
  logic                  cfg_wr_en = 1'b0;
  logic [4:0]            cfg_wr_data = '0;

  decimal_text_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  signed_int_to_decimal_ascii_core #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_FIELD (MAX_FIELD)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_value(in_value);
      if (out_valid && out_ready) sb.check_char(out_character, out_last);
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL signed_int_to_decimal_ascii_core");
      $finish;
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_value(input logic [VALUE_BITS-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Width write, only once the core is idle and every predicted character is out
  task automatic write_width(input logic [4:0] w);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || !in_ready) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    sb.set_width(w);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mix of full-range words, words near the extremes and words of random length
  function automatic logic [VALUE_BITS-1:0] random_value();
    int unsigned           span;
    logic [VALUE_BITS-1:0] word;
    span = 1;
    case ($urandom_range(9))
      0, 1, 2: word = $urandom();
      3: begin
        word = $urandom_range(40);
        word = $urandom_range(1) ? (32'h7FFF_FFFF - word) : (32'h8000_0000 + word);
      end
      default: begin
        repeat ($urandom_range(9, 1)) span = span * 10;
        word = $urandom_range(span - 1);
        if ($urandom_range(1)) word = -word;
      end
    endcase
    return word;
  endfunction

  initial begin
    int mode;
    int seg;
    logic [4:0] w;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 26;
    stall_pct = 72;

    // Directed: no padding, extremes and digit-count boundaries
    write_width(5'd0);
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(9);
    send_value(10);
    send_value(-10);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(1000000000);
    send_value(-999999999);
    send_value(32'h5555_5555);
    send_value(32'hAAAA_AAAA);
    // Width equal to and above the text length
    write_width(5'd11);
    send_value(32'h8000_0000);
    send_value(7);
    send_value(-7);
    // Width above the limit saturates
    write_width(5'd31);
    send_value(0);
    send_value(32'h8000_0000);
    send_value(-1);
    send_value(123);

    // Random phases: three idling modes, several widths each
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 26; stall_pct = 72; end
        1: begin send_idle_pct = 72; stall_pct = 26; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      for (seg = 0; seg < 5; seg++) begin
        case (seg)
          0: w = 5'(MAX_FIELD);
          1: w = 5'($urandom_range(15, 1));
          2: w = 5'd31;
          3: w = 5'd0;
          default: w = 5'($urandom_range(30, MAX_FIELD + 1));
        endcase
        write_width(w);
        repeat (SEG_ITEMS) send_value(random_value());
      end
    end

    // Drain, then watch for stray characters
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS signed_int_to_decimal_ascii_core");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii_core");
    end
    $finish;
  end

endmodule
